// ===== hdl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg: shared types and codes for the inode table allocator
// Field widths, request and status codes, and the default table geometry.
// ----------------------------------------------------------------------------
package ita_pkg;

	localparam int ACTION_W = 3;
	localparam int INODE_W  = 6;
	localparam int BLOCK_W  = 16;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [INODE_W-1:0]  inode_t;
	typedef logic [BLOCK_W-1:0]  block_t;
	typedef logic [TIME_W-1:0]   stamp_t;

	localparam action_t ACT_ALLOC  = 3'd0;
	localparam action_t ACT_FREE   = 3'd1;
	localparam action_t ACT_ADD    = 3'd2;
	localparam action_t ACT_REMOVE = 3'd3;
	localparam action_t ACT_RMALL  = 3'd4;
	localparam action_t ACT_QUERY  = 3'd5;
	localparam action_t ACT_LIST   = 3'd6;

	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_FAIL   = 2'd1;
	localparam status_t STAT_UNUSED = 2'd2;

	localparam int DEF_TABLE_BLOCKS           = 8;
	localparam int DEF_INODES_PER_TABLE_BLOCK = 8;
	localparam int DEF_SLOTS_PER_INODE        = 8;
	localparam int DEF_BLOCK_NUM_BITS         = 16;

endpackage

// ===== hdl/inode_table_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// inode_table_allocator_unit: first-fit inode allocator with block slots
// Each inode row (creation time and block slots) sits in one synchronous
// memory; the free bitmap and a per-table-block summary sit in flip-flops.
// A request is accepted in the idle state and its row is read; the exec
// state modifies and writes the row back and loads the result beat. A
// list with filled slots latches the row in the exec state without sending
// a beat, then the list state sends one beat per cycle while the output is
// not held; a list with no filled slot gives one fail beat. A held output
// stalls the block, and no new request is taken until the last beat is
// loaded. The row of a free inode is never trusted: its free bit masks it
// to all empty slots, so the memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module inode_table_allocator_unit #(
	parameter int TABLE_BLOCKS           = ita_pkg::DEF_TABLE_BLOCKS,
	parameter int INODES_PER_TABLE_BLOCK = ita_pkg::DEF_INODES_PER_TABLE_BLOCK,
	parameter int SLOTS_PER_INODE        = ita_pkg::DEF_SLOTS_PER_INODE,
	parameter int BLOCK_NUM_BITS         = ita_pkg::DEF_BLOCK_NUM_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ita_pkg::action_t action,
	input  ita_pkg::inode_t  inode_num,
	input  ita_pkg::block_t  block_num,
	input  ita_pkg::stamp_t  cur_time,
	output logic             out_valid,
	input  logic             out_ready,
	output ita_pkg::status_t status,
	output ita_pkg::inode_t  inode_out,
	output logic             in_use,
	output ita_pkg::block_t  block_out,
	output logic             last
);
	import ita_pkg::*;

	localparam int NUM_INODES = TABLE_BLOCKS * INODES_PER_TABLE_BLOCK;
	localparam int AW = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
	localparam int GW = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
	localparam int PW = (INODES_PER_TABLE_BLOCK > 1) ? $clog2(INODES_PER_TABLE_BLOCK) : 1;
	localparam int SW = (SLOTS_PER_INODE > 1) ? $clog2(SLOTS_PER_INODE) : 1;
	localparam int BW = BLOCK_NUM_BITS;
	localparam int SLOTS_W = SLOTS_PER_INODE * BW;
	localparam int RW = TIME_W + SLOTS_W;
	localparam logic [BW-1:0] EMPTY_BLK = {BW{1'b1}};

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q, state_d;

	// Row memory
	logic [RW-1:0] mem [NUM_INODES];
	logic [RW-1:0] mem_rd_q;
	logic          mem_re, mem_we;
	logic [RW-1:0] wr_row;

	// Free bitmap and per-table-block summary
	logic [NUM_INODES-1:0]   free_map_q, free_map_d;
	logic [TABLE_BLOCKS-1:0] grp_free_q, grp_free_d;

	// Request registers
	action_t       act_q;
	inode_t        ino_q;
	logic [BW-1:0] blk_q;
	stamp_t        time_q;
	logic [AW-1:0] addr_q;
	logic          found_q;
	logic          range_ok_q;

	// List registers
	logic [SLOTS_W-1:0]         list_q;
	logic [SLOTS_PER_INODE-1:0] pend_q;
	logic                       list_inuse_q;

	// Output register
	logic    out_valid_q;
	status_t status_q;
	inode_t  inode_out_q;
	logic    in_use_q;
	block_t  block_out_q;
	logic    last_q;

	logic accept, out_free, out_load;
	logic range_ok;

	// ------------------------------------------------------------------
	// First-fit search: lowest table block with a free inode, then the
	// lowest free inode inside it.
	// ------------------------------------------------------------------
	logic [GW-1:0]                     grp_sel;
	logic [INODES_PER_TABLE_BLOCK-1:0] grp_bits;
	logic [PW-1:0]                     bit_sel;
	logic                              grant_found;
	logic [AW-1:0]                     grant_idx;

	always_comb begin
		grp_sel = '0;
		bit_sel = '0;
		for (int g = TABLE_BLOCKS - 1; g >= 0; g--) begin
			if (grp_free_q[g]) grp_sel = GW'(g);
		end
		grp_bits = free_map_q[grp_sel * INODES_PER_TABLE_BLOCK +: INODES_PER_TABLE_BLOCK];
		for (int b = INODES_PER_TABLE_BLOCK - 1; b >= 0; b--) begin
			if (grp_bits[b]) bit_sel = PW'(b);
		end
		grant_found = |grp_free_q;
		grant_idx = AW'(int'(grp_sel) * INODES_PER_TABLE_BLOCK + int'(bit_sel));
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign range_ok = (32'(inode_num) < 32'(NUM_INODES));
	assign mem_re   = accept && range_ok && (action != ACT_ALLOC);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action;
			ino_q      <= inode_num;
			blk_q      <= BW'(block_num);
			time_q     <= cur_time;
			range_ok_q <= range_ok;
			found_q    <= grant_found;
			addr_q     <= (action == ACT_ALLOC) ? grant_idx : AW'(inode_num);
		end
	end

	// ------------------------------------------------------------------
	// Read-modify-write of the addressed row
	// ------------------------------------------------------------------
	logic                       fq;
	logic [SLOTS_W-1:0]         row_eff;
	stamp_t                     time_rd;
	logic                       has_empty, has_match;
	logic [SW-1:0]              emp_idx, match_idx;
	logic [SLOTS_PER_INODE-1:0] filled;
	logic [SLOTS_W-1:0]         wr_slots;
	stamp_t                     wr_time;
	logic                       we, free_set, free_clr, go_list;
	status_t                    d_status;
	inode_t                     d_inode;
	logic                       d_inuse;
	logic                       exec_fire;

	assign fq        = free_map_q[addr_q];
	assign time_rd   = mem_rd_q[RW-1 -: TIME_W];
	assign exec_fire = (state_q == S_EXEC) && out_free;

	always_comb begin
		has_empty = 1'b0;
		has_match = 1'b0;
		emp_idx   = '0;
		match_idx = '0;
		for (int s = 0; s < SLOTS_PER_INODE; s++) begin
			// A free inode always holds only empty slots.
			row_eff[s*BW +: BW] = fq ? EMPTY_BLK : mem_rd_q[s*BW +: BW];
			filled[s] = (row_eff[s*BW +: BW] != EMPTY_BLK);
		end
		for (int s = SLOTS_PER_INODE - 1; s >= 0; s--) begin
			if (!filled[s]) begin
				has_empty = 1'b1;
				emp_idx   = SW'(s);
			end
			if (row_eff[s*BW +: BW] == blk_q) begin
				has_match = 1'b1;
				match_idx = SW'(s);
			end
		end
	end

	always_comb begin
		d_status = STAT_OK;
		d_inode  = ino_q;
		d_inuse  = !fq;
		we       = 1'b0;
		wr_slots = row_eff;
		wr_time  = time_rd;
		free_set = 1'b0;
		free_clr = 1'b0;
		go_list  = 1'b0;
		if (act_q == ACT_ALLOC) begin
			if (found_q) begin
				we       = 1'b1;
				wr_slots = {SLOTS_W{1'b1}};
				wr_time  = time_q;
				free_clr = 1'b1;
				d_inode  = INODE_W'(addr_q);
				d_inuse  = 1'b1;
			end else begin
				d_status = STAT_FAIL;
				d_inode  = '0;
				d_inuse  = 1'b0;
			end
		end else if (!range_ok_q) begin
			d_status = STAT_UNUSED;
			d_inuse  = 1'b0;
		end else begin
			unique case (act_q)
				ACT_FREE: begin
					we       = 1'b1;
					wr_slots = {SLOTS_W{1'b1}};
					wr_time  = '0;
					free_set = 1'b1;
					d_inuse  = 1'b0;
				end
				ACT_ADD: begin
					if (fq) begin
						d_status = STAT_UNUSED;
					end else if (blk_q == EMPTY_BLK || !has_empty) begin
						d_status = STAT_FAIL;
					end else begin
						we = 1'b1;
						wr_slots[emp_idx*BW +: BW] = blk_q;
					end
				end
				ACT_REMOVE: begin
					if (blk_q != EMPTY_BLK && has_match) begin
						we = 1'b1;
						wr_slots[match_idx*BW +: BW] = EMPTY_BLK;
					end else begin
						d_status = STAT_FAIL;
					end
				end
				ACT_RMALL: begin
					we       = !fq;
					wr_slots = {SLOTS_W{1'b1}};
				end
				ACT_QUERY: begin
					d_status = STAT_OK;
				end
				ACT_LIST: begin
					if (filled == '0) d_status = STAT_FAIL;
					else go_list = 1'b1;
				end
				default: begin
					d_status = STAT_FAIL;
				end
			endcase
		end
	end

	assign mem_we = exec_fire && we;
	assign wr_row = {wr_time, wr_slots};

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_q] <= wr_row;
		if (mem_re) mem_rd_q <= mem[AW'(inode_num)];
	end

	always_comb begin
		free_map_d = free_map_q;
		if (exec_fire && free_clr) free_map_d[addr_q] = 1'b0;
		if (exec_fire && free_set) free_map_d[addr_q] = 1'b1;
		for (int g = 0; g < TABLE_BLOCKS; g++) begin
			grp_free_d[g] = |free_map_d[g*INODES_PER_TABLE_BLOCK +: INODES_PER_TABLE_BLOCK];
		end
	end

	// ------------------------------------------------------------------
	// List: one filled slot per beat, highest slot first
	// ------------------------------------------------------------------
	logic [SW-1:0]              list_sel;
	logic [SLOTS_PER_INODE-1:0] pend_rest;
	logic                       list_fire;

	always_comb begin
		list_sel = '0;
		for (int s = 0; s < SLOTS_PER_INODE; s++) begin
			if (pend_q[s]) list_sel = SW'(s);
		end
		pend_rest = pend_q;
		pend_rest[list_sel] = 1'b0;
	end

	assign list_fire = (state_q == S_LIST) && out_free;

	always_ff @(posedge clk) begin
		if (exec_fire && go_list) begin
			list_q       <= row_eff;
			list_inuse_q <= !fq;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and control state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_EXEC;
			S_EXEC: if (exec_fire) state_d = go_list ? S_LIST : S_IDLE;
			S_LIST: if (list_fire && pend_rest == '0) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign out_load = (exec_fire && !go_list) || list_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_map_q  <= '1;
			grp_free_q  <= '1;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_map_q <= free_map_d;
			grp_free_q <= grp_free_d;
			if (exec_fire && go_list) pend_q <= filled;
			else if (list_fire) pend_q <= pend_rest;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (list_fire) begin
			status_q    <= STAT_OK;
			inode_out_q <= ino_q;
			in_use_q    <= list_inuse_q;
			block_out_q <= BLOCK_W'(list_q[list_sel*BW +: BW]);
			last_q      <= (pend_rest == '0);
		end else if (out_load) begin
			status_q    <= d_status;
			inode_out_q <= d_inode;
			in_use_q    <= d_inuse;
			block_out_q <= '1;
			last_q      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign inode_out = inode_out_q;
	assign in_use    = in_use_q;
	assign block_out = block_out_q;
	assign last      = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_grp_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_free_q != '0) == (free_map_q != '0))
		else $error("table block summary disagrees with the free bitmap");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && act_q == ACT_ALLOC && found_q) |-> free_map_q[addr_q])
		else $error("granted inode is not free");

	a_grant_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && act_q == ACT_ALLOC && found_q) |=> !free_map_q[$past(addr_q)])
		else $error("granted inode still marked free");

	a_list_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> (pend_q != '0))
		else $error("list state with no slot left to send");

	a_idle_no_list: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (pend_q == '0))
		else $error("new request taken while list beats remain");

endmodule

// ===== tb/ita_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ita_tb_pkg: request and result types plus the inode table scoreboard
// The scoreboard mirrors the allocator's free bitmap and block slots, turns
// every accepted request into the result beats it should produce, and checks
// each output beat against the oldest beat still expected.
// ----------------------------------------------------------------------------
package ita_tb_pkg;
	import ita_pkg::*;

	localparam int NUM_INODES      = DEF_TABLE_BLOCKS * DEF_INODES_PER_TABLE_BLOCK;
	localparam int SLOTS_PER_INODE = DEF_SLOTS_PER_INODE;

	// The package names actions 0 to 6 only; code 7 is not a valid request.
	localparam action_t ACT_UNKNOWN = 3'd7;
	localparam block_t  EMPTY_SLOT  = '1;

	typedef struct {
		action_t action;
		inode_t  inode;
		block_t  block;
		stamp_t  stamp;
	} request_t;

	typedef struct {
		status_t status;
		inode_t  inode;
		logic    in_use;
		block_t  block;
		logic    last;
	} result_t;

	class inode_scoreboard;
		bit      free_map[NUM_INODES];
		block_t  slots[NUM_INODES][SLOTS_PER_INODE];
		stamp_t  created[NUM_INODES];
		result_t expected_q[$];
		int      errors;

		function new();
			errors = 0;
			for (int i = 0; i < NUM_INODES; i++) begin
				free_map[i] = 1'b1;
				created[i] = '0;
				for (int s = 0; s < SLOTS_PER_INODE; s++)
					slots[i][s] = EMPTY_SLOT;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Predicts the beats of one accepted request and updates the table.
		function void note_request(request_t req);
			result_t r;
			int      n;
			int      ino;

			ino = int'(req.inode);
			r.status = STAT_OK;
			r.inode = req.inode;
			r.block = EMPTY_SLOT;
			r.last = 1'b1;
			case (req.action)
				ACT_ALLOC: begin
					r.status = STAT_FAIL;
					r.inode = '0;
					for (int i = 0; i < NUM_INODES; i++) begin
						if (free_map[i]) begin
							free_map[i] = 1'b0;
							created[i] = req.stamp;
							r.status = STAT_OK;
							r.inode = inode_t'(i);
							break;
						end
					end
				end
				ACT_FREE: begin
					for (int s = 0; s < SLOTS_PER_INODE; s++)
						slots[ino][s] = EMPTY_SLOT;
					created[ino] = '0;
					free_map[ino] = 1'b1;
				end
				ACT_ADD: begin
					if (free_map[ino]) begin
						r.status = STAT_UNUSED;
					end else begin
						r.status = STAT_FAIL;
						if (req.block != EMPTY_SLOT) begin
							for (int s = 0; s < SLOTS_PER_INODE; s++) begin
								if (slots[ino][s] == EMPTY_SLOT) begin
									slots[ino][s] = req.block;
									r.status = STAT_OK;
									break;
								end
							end
						end
					end
				end
				ACT_REMOVE: begin
					r.status = STAT_FAIL;
					if (req.block != EMPTY_SLOT) begin
						for (int s = 0; s < SLOTS_PER_INODE; s++) begin
							if (slots[ino][s] == req.block) begin
								slots[ino][s] = EMPTY_SLOT;
								r.status = STAT_OK;
								break;
							end
						end
					end
				end
				ACT_RMALL: begin
					for (int s = 0; s < SLOTS_PER_INODE; s++)
						slots[ino][s] = EMPTY_SLOT;
				end
				ACT_QUERY: begin
				end
				ACT_LIST: begin
					n = 0;
					for (int s = SLOTS_PER_INODE - 1; s >= 0; s--) begin
						if (slots[ino][s] != EMPTY_SLOT) begin
							r.status = STAT_OK;
							r.in_use = !free_map[ino];
							r.block = slots[ino][s];
							r.last = 1'b0;
							expected_q.push_back(r);
							n++;
						end
					end
					if (n > 0) begin
						expected_q[expected_q.size() - 1].last = 1'b1;
						return;
					end
					r.status = STAT_FAIL;
				end
				default: begin
					r.status = STAT_FAIL;
				end
			endcase
			r.in_use = (req.action == ACT_ALLOC) ? (r.status == STAT_OK) : !free_map[ino];
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;

			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: status %0d inode %0d block %0h",
					got.status, got.inode, got.block);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("inode_out", 32'(want.inode), 32'(got.inode));
			compare_field("in_use", 32'(want.in_use), 32'(got.in_use));
			compare_field("block_out", 32'(want.block), 32'(got.block));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for inode_table_allocator_unit
// Drives directed corner cases and then constrained-random request sequences
// through the valid/ready input, with random idling on both sides and one
// long output hold-off, and checks every output beat against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	import ita_pkg::*;
	import ita_tb_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 12;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	action_t action = ACT_QUERY;
	inode_t  inode_num = '0;
	block_t  block_num = '0;
	stamp_t  cur_time = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	status_t status;
	inode_t  inode_out;
	logic    in_use;
	block_t  block_out;
	logic    last;

	inode_scoreboard table_sb = new();

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned hold_requests = 0;
	int          quiet_cycles = 0;

	inode_table_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.inode_num (inode_num),
		.block_num (block_num),
		.cur_time  (cur_time),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.inode_out (inode_out),
		.in_use    (in_use),
		.block_out (block_out),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output side: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int unsigned served;
		int          hold_left;

		served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;

		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.inode = inode_out;
			got.in_use = in_use;
			got.block = block_out;
			got.last = last;
			table_sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL inode_table_allocator_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic request_t mk_request(action_t act, inode_t ino, block_t blk, stamp_t t);
		request_t r;

		r.action = act;
		r.inode = ino;
		r.block = blk;
		r.stamp = t;
		return r;
	endfunction

	// Picks an allocated inode when asked and one exists, otherwise any inode.
	function automatic inode_t pick_inode(bit want_used);
		inode_t used[$];

		for (int i = 0; i < NUM_INODES; i++)
			if (!table_sb.free_map[i])
				used.push_back(inode_t'(i));
		if (want_used && used.size() > 0)
			return used[$urandom_range(used.size() - 1)];
		return inode_t'($urandom_range(NUM_INODES - 1));
	endfunction

	// Block numbers come from a small pool half the time so that duplicates and
	// removes of present blocks are common.
	function automatic request_t random_request();
		request_t r;
		int       pick;

		pick = $urandom_range(99);
		r.stamp = $urandom();
		r.inode = pick_inode($urandom_range(99) < 88);
		if ($urandom_range(1))
			r.block = block_t'($urandom_range(11));
		else
			r.block = block_t'($urandom_range(16'hFFFE));
		if ($urandom_range(99) < 3)
			r.block = EMPTY_SLOT;
		if (pick < 22) begin
			r.action = ACT_ALLOC;
			r.inode = inode_t'($urandom_range(NUM_INODES - 1));
		end else if (pick < 32) begin
			r.action = ACT_FREE;
		end else if (pick < 60) begin
			r.action = ACT_ADD;
		end else if (pick < 75) begin
			r.action = ACT_REMOVE;
			if ($urandom_range(99) < 70)
				r.block = table_sb.slots[r.inode][$urandom_range(SLOTS_PER_INODE - 1)];
		end else if (pick < 80) begin
			r.action = ACT_RMALL;
		end else if (pick < 87) begin
			r.action = ACT_QUERY;
		end else if (pick < 97) begin
			r.action = ACT_LIST;
		end else begin
			r.action = ACT_UNKNOWN;
		end
		return r;
	endfunction

	task automatic send_request(request_t req);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= req.action;
		inode_num <= req.inode;
		block_num <= req.block;
		cur_time <= req.stamp;
		do
			@(posedge clk);
		while (!in_ready);
		table_sb.note_request(req);
	endtask

	task automatic run_random(int count);
		repeat (count)
			send_request(random_request());
	endtask

	initial begin
		block_t fill_blocks[8];

		fill_blocks = '{16'h0000, 16'hFFFE, 16'h0005, 16'h0005,
			16'h8000, 16'h7FFF, 16'h0001, 16'h0002};
		send_idle_pct = 13;
		recv_idle_pct = 81;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests on inodes that were never allocated.
		send_request(mk_request(ACT_QUERY, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_ADD, 6'd5, 16'd1, 32'd0));
		send_request(mk_request(ACT_LIST, 6'd63, 16'd0, 32'd0));
		send_request(mk_request(ACT_FREE, 6'd63, 16'd0, 32'd0));
		send_request(mk_request(ACT_REMOVE, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_RMALL, 6'd63, 16'hFFFF, 32'hFFFF_FFFF));
		send_request(mk_request(ACT_ALLOC, 6'd63, 16'd0, 32'd0));
		send_request(mk_request(ACT_ALLOC, 6'd0, 16'd0, 32'hFFFF_FFFF));
		// The empty marker cannot be added; then fill every slot and overflow.
		send_request(mk_request(ACT_ADD, 6'd0, 16'hFFFF, 32'd0));
		foreach (fill_blocks[i])
			send_request(mk_request(ACT_ADD, 6'd0, fill_blocks[i], 32'd0));
		send_request(mk_request(ACT_ADD, 6'd0, 16'd3, 32'd0));
		send_request(mk_request(ACT_LIST, 6'd0, 16'd0, 32'd0));
		// Duplicate block: only the lowest matching slot goes.
		send_request(mk_request(ACT_REMOVE, 6'd0, 16'd5, 32'd0));
		send_request(mk_request(ACT_REMOVE, 6'd0, 16'hFFFF, 32'd0));
		send_request(mk_request(ACT_REMOVE, 6'd0, 16'd9, 32'd0));
		send_request(mk_request(ACT_LIST, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_UNKNOWN, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_RMALL, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_LIST, 6'd0, 16'd0, 32'd0));
		send_request(mk_request(ACT_FREE, 6'd1, 16'd0, 32'd0));
		send_request(mk_request(ACT_QUERY, 6'd1, 16'd0, 32'd0));
		run_random(140);

		send_idle_pct = 81;
		recv_idle_pct = 13;
		// Exhaust the table so that allocation runs out and freed inodes get reused.
		repeat (NUM_INODES + 2)
			send_request(mk_request(ACT_ALLOC, inode_t'($urandom_range(63)), 16'd0, $urandom()));
		run_random(110);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		run_random(140);

		@(posedge clk);
		in_valid <= 1'b0;
		while (table_sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (table_sb.errors == 0)
			$display("PASS inode_table_allocator_unit");
		else
			$display("FAIL inode_table_allocator_unit");
		$finish;
	end

endmodule
